>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define LCDNS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks through reset
`define LCDNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lcdns_pkg.sv
// Shared types, codes and microcode table of the display nibble sequencer
`default_nettype none

package lcdns_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 17;
    localparam int UADDR_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT   = 3'd5;

    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_CMD    = 3'd1;
    localparam logic [2:0] MODE_DATA   = 3'd2;
    localparam logic [2:0] MODE_CURSOR = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_HOME   = 3'd5;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;

    localparam logic [UADDR_W-1:0] UA_INIT = 5'd0;
    localparam logic [UADDR_W-1:0] UA_BYTE = 5'd24;

    typedef struct packed {
        logic [7:0]  enable_high_us;
        logic [9:0]  nibble_gap_us;
        logic [9:0]  settle_us;
        logic [15:0] long_wait_us;
        logic [15:0] init_first_wait_us;
        logic [9:0]  init_wait_us;
    } t_cfg;

    typedef enum logic [1:0] {
        NS_CONST,
        NS_HI,
        NS_LO
    } t_nsrc;

    typedef enum logic [2:0] {
        HS_ENH,
        HS_GAP,
        HS_SETTLE,
        HS_SETTLE_LONG,
        HS_SETTLE_CLONG,
        HS_IFIRST,
        HS_IWAIT
    } t_hsel;

    typedef struct packed {
        logic       en;
        t_nsrc      nsrc;
        logic [3:0] nib;
        t_hsel      hsel;
        logic       fin;
    } t_uword;

    function automatic t_uword uw(input logic en, input t_nsrc nsrc, input logic [3:0] nib,
                                  input t_hsel hsel, input logic fin);
        t_uword w;
        w.en   = en;
        w.nsrc = nsrc;
        w.nib  = nib;
        w.hsel = hsel;
        w.fin  = fin;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [UADDR_W-1:0] a);
        t_uword w;
        case (a)
            5'd0:    w = uw(1'b1, NS_CONST, 4'h3, HS_ENH,          1'b0);
            5'd1:    w = uw(1'b0, NS_CONST, 4'h3, HS_IFIRST,       1'b0);
            5'd2:    w = uw(1'b1, NS_CONST, 4'h3, HS_ENH,          1'b0);
            5'd3:    w = uw(1'b0, NS_CONST, 4'h3, HS_IWAIT,        1'b0);
            5'd4:    w = uw(1'b1, NS_CONST, 4'h3, HS_ENH,          1'b0);
            5'd5:    w = uw(1'b0, NS_CONST, 4'h3, HS_IWAIT,        1'b0);
            5'd6:    w = uw(1'b1, NS_CONST, 4'h2, HS_ENH,          1'b0);
            5'd7:    w = uw(1'b0, NS_CONST, 4'h2, HS_IWAIT,        1'b0);
            5'd8:    w = uw(1'b1, NS_CONST, 4'h2, HS_ENH,          1'b0);
            5'd9:    w = uw(1'b0, NS_CONST, 4'h2, HS_GAP,          1'b0);
            5'd10:   w = uw(1'b1, NS_CONST, 4'h8, HS_ENH,          1'b0);
            5'd11:   w = uw(1'b0, NS_CONST, 4'h8, HS_SETTLE,       1'b0);
            5'd12:   w = uw(1'b1, NS_CONST, 4'h0, HS_ENH,          1'b0);
            5'd13:   w = uw(1'b0, NS_CONST, 4'h0, HS_GAP,          1'b0);
            5'd14:   w = uw(1'b1, NS_CONST, 4'hC, HS_ENH,          1'b0);
            5'd15:   w = uw(1'b0, NS_CONST, 4'hC, HS_SETTLE,       1'b0);
            5'd16:   w = uw(1'b1, NS_CONST, 4'h0, HS_ENH,          1'b0);
            5'd17:   w = uw(1'b0, NS_CONST, 4'h0, HS_GAP,          1'b0);
            5'd18:   w = uw(1'b1, NS_CONST, 4'h6, HS_ENH,          1'b0);
            5'd19:   w = uw(1'b0, NS_CONST, 4'h6, HS_SETTLE,       1'b0);
            5'd20:   w = uw(1'b1, NS_CONST, 4'h0, HS_ENH,          1'b0);
            5'd21:   w = uw(1'b0, NS_CONST, 4'h0, HS_GAP,          1'b0);
            5'd22:   w = uw(1'b1, NS_CONST, 4'h1, HS_ENH,          1'b0);
            5'd23:   w = uw(1'b0, NS_CONST, 4'h1, HS_SETTLE_LONG,  1'b1);
            5'd24:   w = uw(1'b1, NS_HI,    4'h0, HS_ENH,          1'b0);
            5'd25:   w = uw(1'b0, NS_HI,    4'h0, HS_GAP,          1'b0);
            5'd26:   w = uw(1'b1, NS_LO,    4'h0, HS_ENH,          1'b0);
            5'd27:   w = uw(1'b0, NS_LO,    4'h0, HS_SETTLE_CLONG, 1'b1);
            default: w = uw(1'b0, NS_CONST, 4'h0, HS_GAP,          1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/char_lcd_nibble_sequencer.sv
// Top level: microcode sequencer that turns display requests into bus phases
//
//  channel   dir  handshake                 payload
//  in        in   i_in_valid / o_in_stall   i_in_mode, i_in_value, i_in_row, i_in_column
//  out       out  o_out_valid / i_out_stall o_out_reg_select, o_out_enable_pin,
//                                           o_out_data_nibble, o_out_hold_us, o_out_last
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One control word per cycle while the output is not stalled, one phase per word: a
//  byte request gives four phases and init 24, after the accept; the step counter sets this pace.
//  The next request is taken the cycle after its final phase enters the output register.
//  Modes 6 and 7 are taken and produce no phase.
//  Reset loads the timing defaults and idles the sequencer; no clearing pass.
//  Output stall freezes the output register and the step counter.
`default_nettype none

module char_lcd_nibble_sequencer import lcdns_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_in_mode,
    input  wire logic [7:0]            i_in_value,
    input  wire logic                  i_in_row,
    input  wire logic [5:0]            i_in_column,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_out_reg_select,
    output logic                       o_out_enable_pin,
    output logic [3:0]                 o_out_data_nibble,
    output logic [HOLD_W-1:0]          o_out_hold_us,
    output logic                       o_out_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state              r_state;
    logic [UADDR_W-1:0]  r_step;
    logic [7:0]          r_byte;
    logic                r_rs;
    logic                r_long;
    logic                r_out_valid;
    logic                r_out_rs;
    logic                r_out_en;
    logic [3:0]          r_out_nib;
    logic [HOLD_W-1:0]   r_out_hold;
    logic                r_out_last;

    t_cfg                w_cfg;
    t_uword              w_uword;
    logic                w_accept;
    logic                w_load;
    logic                w_enable;
    logic [3:0]          w_nibble;
    logic [HOLD_W-1:0]   w_hold;

    lcdns_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_uword = ucode(r_step);

    lcdns_phase_dp u_dp (
        .i_uword  (w_uword),
        .i_cfg    (w_cfg),
        .i_byte   (r_byte),
        .i_long   (r_long),
        .o_enable (w_enable),
        .o_nibble (w_nibble),
        .o_hold   (w_hold)
    );

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_load   = (r_state == ST_RUN) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= UA_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_step <= UA_BYTE;
                r_rs   <= 1'b0;
                r_long <= 1'b0;
                r_byte <= i_in_value;
                case (i_in_mode)
                    MODE_INIT: begin
                        r_state <= ST_RUN;
                        r_step  <= UA_INIT;
                    end
                    MODE_CMD: begin
                        r_state <= ST_RUN;
                    end
                    MODE_DATA: begin
                        r_state <= ST_RUN;
                        r_rs    <= 1'b1;
                    end
                    MODE_CURSOR: begin
                        r_state <= ST_RUN;
                        r_byte  <= {1'b1, i_in_row, i_in_column};
                    end
                    MODE_CLEAR: begin
                        r_state <= ST_RUN;
                        r_byte  <= CMD_CLEAR;
                        r_long  <= 1'b1;
                    end
                    MODE_HOME: begin
                        r_state <= ST_RUN;
                        r_byte  <= CMD_HOME;
                        r_long  <= 1'b1;
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end

            if (w_load) begin
                r_step      <= r_step + UADDR_W'(1);
                r_out_valid <= 1'b1;
                r_out_rs    <= r_rs;
                r_out_en    <= w_enable;
                r_out_nib   <= w_nibble;
                r_out_hold  <= w_hold;
                r_out_last  <= w_uword.fin;
                if (w_uword.fin) begin
                    r_state <= ST_IDLE;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_reg_select  = r_out_rs;
    assign o_out_enable_pin  = r_out_en;
    assign o_out_data_nibble = r_out_nib;
    assign o_out_hold_us     = r_out_hold;
    assign o_out_last        = r_out_last;
    assign o_cfg_ready       = 1'b1;

endmodule

`default_nettype wire

>>> rtl/core/lcdns_cfg_regs.sv
// Timing register file of the display nibble sequencer
`default_nettype none

module lcdns_cfg_regs import lcdns_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high_us     <= 8'd1;
            r_cfg.nibble_gap_us      <= 10'd50;
            r_cfg.settle_us          <= 10'd100;
            r_cfg.long_wait_us       <= 16'd5000;
            r_cfg.init_first_wait_us <= 16'd5000;
            r_cfg.init_wait_us       <= 10'd150;
        end else if (i_wr) begin
            case (i_index)
                CFG_ENABLE_HIGH: r_cfg.enable_high_us     <= i_data[7:0];
                CFG_NIBBLE_GAP:  r_cfg.nibble_gap_us      <= i_data[9:0];
                CFG_SETTLE:      r_cfg.settle_us          <= i_data[9:0];
                CFG_LONG_WAIT:   r_cfg.long_wait_us       <= i_data;
                CFG_INIT_FIRST:  r_cfg.init_first_wait_us <= i_data;
                CFG_INIT_WAIT:   r_cfg.init_wait_us       <= i_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/lcdns_phase_dp.sv
// Phase datapath: decodes one control word into nibble, enable and hold time
`default_nettype none

module lcdns_phase_dp import lcdns_pkg::*; (
    input  t_uword                 i_uword,
    input  t_cfg                   i_cfg,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_long,
    output logic                   o_enable,
    output logic [3:0]             o_nibble,
    output logic [HOLD_W-1:0]      o_hold
);

    logic [HOLD_W-1:0] w_a;
    logic [HOLD_W-1:0] w_b;
    logic [HOLD_W-1:0] w_base;

    always_comb begin
        case (i_uword.nsrc)
            NS_HI:   o_nibble = i_byte[7:4];
            NS_LO:   o_nibble = i_byte[3:0];
            default: o_nibble = i_uword.nib;
        endcase
    end

    always_comb begin
        w_base = HOLD_W'(i_cfg.nibble_gap_us);
        w_a    = '0;
        w_b    = '0;
        case (i_uword.hsel)
            HS_ENH: begin
                w_base = HOLD_W'(i_cfg.enable_high_us);
            end
            HS_SETTLE: begin
                w_a = HOLD_W'(i_cfg.settle_us);
            end
            HS_SETTLE_LONG: begin
                w_a = HOLD_W'(i_cfg.settle_us);
                w_b = HOLD_W'(i_cfg.long_wait_us);
            end
            HS_SETTLE_CLONG: begin
                w_a = HOLD_W'(i_cfg.settle_us);
                w_b = i_long ? HOLD_W'(i_cfg.long_wait_us) : '0;
            end
            HS_IFIRST: begin
                w_a = HOLD_W'(i_cfg.init_first_wait_us);
            end
            HS_IWAIT: begin
                w_a = HOLD_W'(i_cfg.init_wait_us);
            end
            default: begin
            end
        endcase
    end

    assign o_hold   = w_base + w_a + w_b;
    assign o_enable = i_uword.en;

endmodule

`default_nettype wire

>>> rtl/core/lcdns_checker.sv
// Port-level checker for the display nibble sequencer, with its bind
`default_nettype none
`include "assert_macros.svh"

module lcdns_checker import lcdns_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic [2:0]            i_in_mode,
    input wire logic [7:0]            i_in_value,
    input wire logic                  i_in_row,
    input wire logic [5:0]            i_in_column,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic                  o_out_reg_select,
    input wire logic                  o_out_enable_pin,
    input wire logic [3:0]            o_out_data_nibble,
    input wire logic [HOLD_W-1:0]     o_out_hold_us,
    input wire logic                  o_out_last,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    `LCDNS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable({o_out_reg_select, o_out_enable_pin, o_out_data_nibble, o_out_hold_us, o_out_last}), "stalled item changed")
    `LCDNS_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_mode == MODE_INIT || i_in_mode == MODE_CMD || i_in_mode == MODE_DATA || i_in_mode == MODE_CURSOR || i_in_mode == MODE_CLEAR || i_in_mode == MODE_HOME) |=> o_in_stall, "request not held busy")
    `LCDNS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle after reset")
    `LCDNS_ASSERT(a_last_low, i_clk, i_rst_n, o_out_valid && o_out_last |-> !o_out_enable_pin, "final phase has enable high")
    `LCDNS_ASSERT(a_enh_short, i_clk, i_rst_n, o_out_valid && o_out_enable_pin |-> !o_out_last && o_out_hold_us[16:8] == 9'd0, "enable-high phase malformed")

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (.*);

`default_nettype wire
